### hdl/mpam_pkg.sv
// Shared types and codes for the multi-pattern automaton matcher.
package mpam_pkg;

    typedef enum logic [1:0] {
        K_PAT   = 2'd0,
        K_BUILD = 2'd1,
        K_TEXT  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNBUILT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PI_CHK,
        S_PI_END,
        S_TX_CHK,
        S_TX_END,
        S_B_POP,
        S_B_FAIL,
        S_B_ENDS,
        S_B_MARK,
        S_B_RD,
        S_B_WR
    } state_t;

    typedef struct packed {
        logic goto_we;
        logic fail_we;
        logic ends_we;
    } tbl_we_t;

endpackage

### hdl/multi_pattern_automaton_matcher.sv
// Aho-Corasick matcher: trie insertion, breadth-first link build, text stepping.
// No-op and stopped-pattern items answer from S_IDLE; pattern letters pass S_PI_CHK, and then
// S_PI_END for an existing node; text letters pass S_TX_CHK and S_TX_END. Build: per trie node
// S_B_POP, S_B_FAIL, S_B_ENDS, S_B_MARK, then S_B_RD and S_B_WR per letter, since the single
// goto-table port pair is reused for each letter. One transaction at a time; the next may
// start in the cycle done is high; no stall. After reset the tables are swept to zero, all
// NODES * 2**clog2(ALPHABET) goto entries (32768 by default), with busy high.
module multi_pattern_automaton_matcher #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 26
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] kind,
    input  logic [4:0] letter,
    input  logic       last,
    output logic       busy,
    output logic       done,
    output logic       matched,
    output logic [9:0] node,
    output logic [1:0] status
);
    localparam int NW  = $clog2(NODES);
    localparam int LW  = $clog2(ALPHABET);
    localparam int GAW = NW + LW;
    localparam logic [NW:0]   NODES_W  = (NW+1)'(NODES);
    localparam logic [8:0]    ALPH9    = 9'(ALPHABET);
    localparam logic [LW-1:0] LAST_LET = LW'(ALPHABET - 1);

    mpam_pkg::state_t  state_reg, state_next;
    mpam_pkg::status_t status_reg, status_next;

    logic [NW-1:0] node_count_reg, node_count_next;
    logic [NW-1:0] ins_cur_reg, ins_cur_next;
    logic          ins_stop_reg, ins_stop_next;
    logic [NW-1:0] txt_cur_reg, txt_cur_next;
    logic          built_reg, built_next;
    logic [LW-1:0] let_reg, let_next;
    logic          last_reg, last_next;
    logic [NW-1:0] g_reg, g_next;
    logic [NW-1:0] u_reg, u_next;
    logic [NW-1:0] v_reg, v_next;
    logic [LW-1:0] i_reg, i_next;
    logic [NW:0]   head_reg, head_next;
    logic [NW:0]   tail_reg, tail_next;
    logic          done_reg, done_next;
    logic          matched_reg, matched_next;
    logic [NW-1:0] node_reg, node_next;

    logic            accept;
    logic            let_ok;
    logic [LW+4:0]   let_ext;
    logic [LW-1:0]   let_in;
    logic [NW:0]     nc_plus;
    logic [NW-1:0]   nc_new;
    logic [NW+9:0]   node_ext;

    mpam_pkg::tbl_we_t tbl_we;
    logic [GAW-1:0] goto_ra0, goto_ra1, goto_wa;
    logic [NW-1:0]  goto_wd, fail_ra, fail_wa, fail_wd, ends_ra, ends_wa;
    logic           ends_wd;
    logic [NW-1:0]  goto_rd0, goto_rd1, fail_rd;
    logic           ends_rd;
    logic           tbl_ready;
    logic           q_we;
    logic [NW-1:0]  q_wa, q_wd, q_ra, q_rd;

    mpam_tables #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) u_tables (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (tbl_we),
        .goto_ra0 (goto_ra0),
        .goto_ra1 (goto_ra1),
        .goto_wa  (goto_wa),
        .goto_wd  (goto_wd),
        .fail_ra  (fail_ra),
        .fail_wa  (fail_wa),
        .fail_wd  (fail_wd),
        .ends_ra  (ends_ra),
        .ends_wa  (ends_wa),
        .ends_wd  (ends_wd),
        .goto_rd0 (goto_rd0),
        .goto_rd1 (goto_rd1),
        .fail_rd  (fail_rd),
        .ends_rd  (ends_rd),
        .ready    (tbl_ready)
    );

    mpam_queue #(
        .NODES (NODES)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_wa),
        .wdata (q_wd),
        .raddr (q_ra),
        .rdata (q_rd)
    );

    assign busy    = (state_reg != mpam_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign let_ok  = ({4'b0, letter} < ALPH9);
    assign let_ext = {{LW{1'b0}}, letter};
    assign let_in  = let_ext[LW-1:0];
    assign nc_plus = {1'b0, node_count_reg} + (NW+1)'(1);
    assign nc_new  = nc_plus[NW-1:0];

    // next state and registered values
    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        ins_cur_next    = ins_cur_reg;
        ins_stop_next   = ins_stop_reg;
        txt_cur_next    = txt_cur_reg;
        built_next      = built_reg;
        let_next        = let_reg;
        last_next       = last_reg;
        g_next          = g_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        i_next          = i_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        done_next       = 1'b0;
        matched_next    = 1'b0;
        node_next       = node_reg;
        status_next     = status_reg;

        unique case (state_reg)
            mpam_pkg::S_CLEAR:
            begin
                if (tbl_ready)
                begin
                    state_next = mpam_pkg::S_IDLE;
                end
            end
            mpam_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        mpam_pkg::K_PAT:
                        begin
                            if (built_reg || !let_ok)
                            begin
                                done_next   = 1'b1;
                                node_next   = ins_cur_reg;
                                status_next = mpam_pkg::ST_OK;
                            end
                            else if (ins_stop_reg)
                            begin
                                done_next   = 1'b1;
                                node_next   = ins_cur_reg;
                                status_next = mpam_pkg::ST_OK;
                                if (last)
                                begin
                                    ins_cur_next  = '0;
                                    ins_stop_next = 1'b0;
                                end
                            end
                            else
                            begin
                                let_next   = let_in;
                                last_next  = last;
                                state_next = mpam_pkg::S_PI_CHK;
                            end
                        end
                        mpam_pkg::K_BUILD:
                        begin
                            if (built_reg)
                            begin
                                done_next   = 1'b1;
                                node_next   = '0;
                                status_next = mpam_pkg::ST_OK;
                            end
                            else
                            begin
                                head_next  = '0;
                                tail_next  = (NW+1)'(1);
                                state_next = mpam_pkg::S_B_POP;
                            end
                        end
                        mpam_pkg::K_TEXT:
                        begin
                            if (!built_reg)
                            begin
                                done_next   = 1'b1;
                                node_next   = txt_cur_reg;
                                status_next = mpam_pkg::ST_UNBUILT;
                            end
                            else if (!let_ok)
                            begin
                                done_next   = 1'b1;
                                node_next   = txt_cur_reg;
                                status_next = mpam_pkg::ST_OK;
                            end
                            else
                            begin
                                let_next   = let_in;
                                state_next = mpam_pkg::S_TX_CHK;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            node_next   = '0;
                            status_next = mpam_pkg::ST_OK;
                        end
                    endcase
                end
            end
            mpam_pkg::S_PI_CHK:
            begin
                if (goto_rd0 == '0)
                begin
                    state_next = mpam_pkg::S_IDLE;
                    done_next  = 1'b1;
                    if (nc_plus < NODES_W)
                    begin
                        node_count_next = nc_new;
                        node_next       = nc_new;
                        status_next     = mpam_pkg::ST_OK;
                        ins_cur_next    = last_reg ? '0 : nc_new;
                    end
                    else
                    begin
                        node_next     = ins_cur_reg;
                        status_next   = mpam_pkg::ST_FULL;
                        ins_stop_next = !last_reg;
                        if (last_reg)
                        begin
                            ins_cur_next = '0;
                        end
                    end
                end
                else
                begin
                    g_next     = goto_rd0;
                    state_next = mpam_pkg::S_PI_END;
                end
            end
            mpam_pkg::S_PI_END:
            begin
                state_next  = mpam_pkg::S_IDLE;
                done_next   = 1'b1;
                node_next   = g_reg;
                status_next = mpam_pkg::ST_OK;
                if (last_reg)
                begin
                    ins_cur_next  = '0;
                    ins_stop_next = 1'b0;
                end
                else
                begin
                    ins_cur_next  = g_reg;
                    ins_stop_next = ends_rd;
                end
            end
            mpam_pkg::S_TX_CHK:
            begin
                g_next     = goto_rd0;
                state_next = mpam_pkg::S_TX_END;
            end
            mpam_pkg::S_TX_END:
            begin
                state_next   = mpam_pkg::S_IDLE;
                txt_cur_next = g_reg;
                done_next    = 1'b1;
                matched_next = ends_rd;
                node_next    = g_reg;
                status_next  = mpam_pkg::ST_OK;
            end
            mpam_pkg::S_B_POP:
            begin
                head_next  = head_reg + (NW+1)'(1);
                state_next = mpam_pkg::S_B_FAIL;
            end
            mpam_pkg::S_B_FAIL:
            begin
                u_next     = q_rd;
                state_next = mpam_pkg::S_B_ENDS;
            end
            mpam_pkg::S_B_ENDS:
            begin
                v_next     = fail_rd;
                state_next = mpam_pkg::S_B_MARK;
            end
            mpam_pkg::S_B_MARK:
            begin
                i_next     = '0;
                state_next = mpam_pkg::S_B_RD;
            end
            mpam_pkg::S_B_RD:
            begin
                state_next = mpam_pkg::S_B_WR;
            end
            mpam_pkg::S_B_WR:
            begin
                if ((goto_rd0 != '0) && (tail_reg < NODES_W))
                begin
                    tail_next = tail_reg + (NW+1)'(1);
                end
                if (i_reg == LAST_LET)
                begin
                    if (head_reg < tail_next)
                    begin
                        state_next = mpam_pkg::S_B_POP;
                    end
                    else
                    begin
                        built_next  = 1'b1;
                        done_next   = 1'b1;
                        node_next   = '0;
                        status_next = mpam_pkg::ST_OK;
                        state_next  = mpam_pkg::S_IDLE;
                    end
                end
                else
                begin
                    i_next     = i_reg + LW'(1);
                    state_next = mpam_pkg::S_B_RD;
                end
            end
            default:
            begin
                state_next = mpam_pkg::S_IDLE;
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        tbl_we   = '0;
        goto_ra0 = {ins_cur_reg, let_in};
        goto_ra1 = {v_reg, i_reg};
        goto_wa  = {u_reg, i_reg};
        goto_wd  = goto_rd1;
        fail_ra  = q_rd;
        fail_wa  = goto_rd0;
        fail_wd  = (u_reg == '0) ? '0 : goto_rd1;
        ends_ra  = goto_rd0;
        ends_wa  = u_reg;
        ends_wd  = 1'b1;
        q_we     = 1'b0;
        q_wa     = tail_reg[NW-1:0];
        q_wd     = goto_rd0;
        q_ra     = head_reg[NW-1:0];

        unique case (state_reg)
            mpam_pkg::S_IDLE:
            begin
                if (kind == mpam_pkg::K_TEXT)
                begin
                    goto_ra0 = {txt_cur_reg, let_in};
                end
                if (accept && (kind == mpam_pkg::K_BUILD) && !built_reg)
                begin
                    q_we = 1'b1;
                    q_wa = '0;
                    q_wd = '0;
                end
            end
            mpam_pkg::S_PI_CHK:
            begin
                if ((goto_rd0 == '0) && (nc_plus < NODES_W))
                begin
                    tbl_we.goto_we = 1'b1;
                    goto_wa        = {ins_cur_reg, let_reg};
                    goto_wd        = nc_new;
                    if (last_reg)
                    begin
                        tbl_we.ends_we = 1'b1;
                        ends_wa        = nc_new;
                    end
                end
            end
            mpam_pkg::S_PI_END:
            begin
                if (!ends_rd && last_reg)
                begin
                    tbl_we.ends_we = 1'b1;
                    ends_wa        = g_reg;
                end
            end
            mpam_pkg::S_B_ENDS:
            begin
                ends_ra = fail_rd;
            end
            mpam_pkg::S_B_MARK:
            begin
                tbl_we.ends_we = ends_rd;
            end
            mpam_pkg::S_B_RD:
            begin
                goto_ra0 = {u_reg, i_reg};
            end
            mpam_pkg::S_B_WR:
            begin
                if (goto_rd0 != '0)
                begin
                    tbl_we.fail_we = 1'b1;
                    q_we           = (tail_reg < NODES_W);
                end
                else
                begin
                    tbl_we.goto_we = 1'b1;
                end
            end
            default:
            begin
                tbl_we = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mpam_pkg::S_CLEAR;
            node_count_reg <= '0;
            ins_cur_reg    <= '0;
            ins_stop_reg   <= 1'b0;
            txt_cur_reg    <= '0;
            built_reg      <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            ins_cur_reg    <= ins_cur_next;
            ins_stop_reg   <= ins_stop_next;
            txt_cur_reg    <= txt_cur_next;
            built_reg      <= built_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        let_reg     <= let_next;
        last_reg    <= last_next;
        g_reg       <= g_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        i_reg       <= i_next;
        matched_reg <= matched_next;
        node_reg    <= node_next;
        status_reg  <= status_next;
    end

    assign node_ext = {10'b0, node_reg};
    assign done     = done_reg;
    assign matched  = matched_reg;
    assign node     = node_ext[9:0];
    assign status   = status_reg;

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(accept) || $past(busy)))
        else $error("result strobe without a transaction");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, node_count_reg} < NODES_W))
        else $error("node count reached table size");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == mpam_pkg::ST_FULL)) |->
            (nc_plus == NODES_W))
        else $error("table-full status with free nodes");

    a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && matched) |-> (status == mpam_pkg::ST_OK))
        else $error("match reported with error status");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= tail_reg) && (tail_reg <= NODES_W))
        else $error("walk queue pointers out of order");

endmodule

### hdl/mpam_queue.sv
// Breadth-first walk queue memory, one write and one registered read port.
module mpam_queue #(
    parameter int NODES = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(NODES)-1:0] waddr,
    input  logic [$clog2(NODES)-1:0] wdata,
    input  logic [$clog2(NODES)-1:0] raddr,
    output logic [$clog2(NODES)-1:0] rdata
);
    localparam int NW = $clog2(NODES);

    logic [NW-1:0] mem [NODES];
    logic [NW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mpam_tables.sv
// Goto, failure-link and end-mark memories with the post-reset clearing sweep.
module mpam_tables #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 26
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  mpam_pkg::tbl_we_t                           we,
    input  logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]   goto_ra0,
    input  logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]   goto_ra1,
    input  logic [$clog2(NODES)+$clog2(ALPHABET)-1:0]   goto_wa,
    input  logic [$clog2(NODES)-1:0]                    goto_wd,
    input  logic [$clog2(NODES)-1:0]                    fail_ra,
    input  logic [$clog2(NODES)-1:0]                    fail_wa,
    input  logic [$clog2(NODES)-1:0]                    fail_wd,
    input  logic [$clog2(NODES)-1:0]                    ends_ra,
    input  logic [$clog2(NODES)-1:0]                    ends_wa,
    input  logic                                        ends_wd,
    output logic [$clog2(NODES)-1:0]                    goto_rd0,
    output logic [$clog2(NODES)-1:0]                    goto_rd1,
    output logic [$clog2(NODES)-1:0]                    fail_rd,
    output logic                                        ends_rd,
    output logic                                        ready
);
    localparam int NW  = $clog2(NODES);
    localparam int LW  = $clog2(ALPHABET);
    localparam int GAW = NW + LW;
    localparam int GD  = NODES * (1 << LW);
    localparam logic [GAW-1:0] CLR_LAST = GAW'(GD - 1);
    localparam logic [GAW-1:0] NODES_G  = GAW'(NODES);

    logic [NW-1:0] goto_mem [GD];
    logic [NW-1:0] fail_mem [NODES];
    logic          ends_mem [NODES];

    logic [GAW-1:0] clr_cnt_reg;
    logic [GAW-1:0] clr_cnt_next;
    logic           clr_busy_reg;
    logic           clr_busy_next;

    logic [NW-1:0] goto_rd0_reg;
    logic [NW-1:0] goto_rd1_reg;
    logic [NW-1:0] fail_rd_reg;
    logic          ends_rd_reg;

    logic           g_we;
    logic [GAW-1:0] g_wa;
    logic [NW-1:0]  g_wd;
    logic           f_we;
    logic [NW-1:0]  f_wa;
    logic [NW-1:0]  f_wd;
    logic           e_we;
    logic [NW-1:0]  e_wa;
    logic           e_wd;
    logic           clr_small;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + GAW'(1);
            if (clr_cnt_reg == CLR_LAST)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    assign clr_small = clr_busy_reg && (clr_cnt_reg < NODES_G);

    // sweep owns all write ports while clearing
    always_comb
    begin
        g_we = clr_busy_reg ? 1'b1 : we.goto_we;
        g_wa = clr_busy_reg ? clr_cnt_reg : goto_wa;
        g_wd = clr_busy_reg ? '0 : goto_wd;
        f_we = clr_busy_reg ? clr_small : we.fail_we;
        f_wa = clr_busy_reg ? clr_cnt_reg[NW-1:0] : fail_wa;
        f_wd = clr_busy_reg ? '0 : fail_wd;
        e_we = clr_busy_reg ? clr_small : we.ends_we;
        e_wa = clr_busy_reg ? clr_cnt_reg[NW-1:0] : ends_wa;
        e_wd = clr_busy_reg ? 1'b0 : ends_wd;
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            goto_mem[g_wa] <= g_wd;
        end
        goto_rd0_reg <= goto_mem[goto_ra0];
        goto_rd1_reg <= goto_mem[goto_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fail_mem[f_wa] <= f_wd;
        end
        fail_rd_reg <= fail_mem[fail_ra];
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            ends_mem[e_wa] <= e_wd;
        end
        ends_rd_reg <= ends_mem[ends_ra];
    end

    assign goto_rd0 = goto_rd0_reg;
    assign goto_rd1 = goto_rd1_reg;
    assign fail_rd  = fail_rd_reg;
    assign ends_rd  = ends_rd_reg;
    assign ready    = !clr_busy_reg;

endmodule

### tb/tb_multi_pattern_automaton_matcher.sv
// Self-checking testbench for the multi-pattern automaton matcher.
`timescale 1ns / 100ps

module tb_multi_pattern_automaton_matcher;

    localparam int NODES      = 1024;
    localparam int ALPHA      = 26;
    localparam logic [1:0] K_NONE = 2'd3;   // unused kind code, a no-op
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct {
        bit       matched;
        bit [9:0] node;
        bit [1:0] status;
    } match_result_t;

    class match_scoreboard;
        int            trans_tbl [NODES*ALPHA];
        int            fail_tbl [NODES];
        bit            end_tbl [NODES];
        int            walk_q [NODES];
        int            node_cnt;
        int            ins_cur;
        bit            ins_stop;
        int            txt_cur;
        bit            built;
        match_result_t pending [$];
        int            errors;
        int            n_checked;
        int            n_match;
        int            n_full;

        function new();
            foreach (trans_tbl[i]) trans_tbl[i] = 0;
            foreach (fail_tbl[i]) fail_tbl[i] = 0;
            foreach (end_tbl[i]) end_tbl[i] = 0;
            node_cnt = 0; ins_cur = 0; ins_stop = 0; txt_cur = 0; built = 0;
            errors = 0; n_checked = 0; n_match = 0; n_full = 0;
        endfunction

        // breadth-first walk: failure links, filled transitions, spread end marks
        function void build_links();
            int head;
            int tail;
            int u;
            int v;
            int c;
            head = 0;
            tail = 0;
            walk_q[tail++] = 0;
            while (head < tail) begin
                u = walk_q[head % NODES];
                head++;
                v = fail_tbl[u] % NODES;
                if (end_tbl[v]) end_tbl[u] = 1;
                for (int i = 0; i < ALPHA; i++) begin
                    c = trans_tbl[u*ALPHA + i] % NODES;
                    if (c != 0) begin
                        fail_tbl[c] = (u == 0) ? 0 : trans_tbl[v*ALPHA + i];
                        if (tail < NODES) walk_q[tail++] = c;
                    end else begin
                        trans_tbl[u*ALPHA + i] = trans_tbl[v*ALPHA + i];
                    end
                end
            end
        endfunction

        function void note_item(logic [1:0] k, logic [4:0] l, logic lst);
            match_result_t r;
            int p;
            int idx;
            r.matched = 0; r.node = 0; r.status = mpam_pkg::ST_OK;
            if (k == mpam_pkg::K_PAT) begin
                if (built || l >= ALPHA) begin
                    r.node = 10'(ins_cur);
                end else begin
                    p = ins_cur;
                    if (!ins_stop) begin
                        idx = p*ALPHA + l;
                        if (trans_tbl[idx] == 0) begin
                            if (node_cnt + 1 < NODES) begin
                                node_cnt++;
                                trans_tbl[idx] = node_cnt;
                            end else begin
                                r.status = mpam_pkg::ST_FULL;
                                ins_stop = 1;
                            end
                        end
                        if (r.status == mpam_pkg::ST_OK) begin
                            p = trans_tbl[idx];
                            if (end_tbl[p]) ins_stop = 1;
                            else if (lst) end_tbl[p] = 1;
                        end
                    end
                    ins_cur = p;
                    r.node = 10'(p);
                    if (lst) begin
                        ins_cur = 0;
                        ins_stop = 0;
                    end
                end
                if (r.status == mpam_pkg::ST_FULL) n_full++;
            end else if (k == mpam_pkg::K_BUILD) begin
                if (!built) begin
                    build_links();
                    built = 1;
                end
            end else if (k == mpam_pkg::K_TEXT) begin
                if (!built) begin
                    r.node = 10'(txt_cur);
                    r.status = mpam_pkg::ST_UNBUILT;
                end else if (l >= ALPHA) begin
                    r.node = 10'(txt_cur);
                end else begin
                    txt_cur = trans_tbl[txt_cur*ALPHA + l] % NODES;
                    r.node = 10'(txt_cur);
                    r.matched = end_tbl[txt_cur];
                    if (r.matched) n_match++;
                end
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic m, logic [9:0] n, logic [1:0] s);
            match_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result matched=%0d node=%0d status=%0d",
                         $time, m, n, s);
                errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (m !== e.matched) begin
                $display("%0t: matched mismatch exp %0d got %0d", $time, e.matched, m);
                errors++;
            end
            if (n !== e.node) begin
                $display("%0t: node mismatch exp %0d got %0d", $time, e.node, n);
                errors++;
            end
            if (s !== e.status) begin
                $display("%0t: status mismatch exp %0d got %0d", $time, e.status, s);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic [1:0] kind;
    logic [4:0] letter;
    logic       last;
    logic       busy;
    logic       done;
    logic       matched;
    logic [9:0] node;
    logic [1:0] status;

    match_scoreboard sb;
    int cycles;
    int n_items;
    int idle_pct;

    multi_pattern_automaton_matcher u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .letter  (letter),
        .last    (last),
        .busy    (busy),
        .done    (done),
        .matched (matched),
        .node    (node),
        .status  (status)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // monitor: accepted transactions and result strobes
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) sb.note_item(kind, letter, last);
            if (done) sb.check_result(matched, node, status);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(int k, int l, int lst);
        int gap;
        gap = 0;
        idle_pct = (n_items / 150 % 3 == 0) ? 0 : (n_items / 150 % 3 == 1) ? 73 : 6;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1;
        kind   <= 2'(k);
        letter <= 5'(l);
        last   <= 1'(lst);
        do @(posedge clk); while (busy);
        n_items++;
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task automatic send_pattern(int len, int lo, int hi);
        for (int i = 0; i < len; i++)
            send(mpam_pkg::K_PAT, $urandom_range(hi, lo), i == len - 1);
    endtask

    initial begin
        int r;
        sb = new();
        cycles = 0;
        n_items = 0;
        rst_n = 0;
        start = 0;
        kind = mpam_pkg::K_PAT;
        letter = 0;
        last = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;

        // directed: text before build, out-of-range letters, unused kind
        send(mpam_pkg::K_TEXT, 0, 0);
        send(mpam_pkg::K_TEXT, 31, 1);
        send(K_NONE, 31, 1);
        send(mpam_pkg::K_PAT, 31, 1);
        // "a" ends; then "ab" stops at a
        send(mpam_pkg::K_PAT, 0, 1);
        send(mpam_pkg::K_PAT, 0, 0);
        send(mpam_pkg::K_PAT, 1, 1);
        // "zyx", with an out-of-range letter in the middle
        send(mpam_pkg::K_PAT, 25, 0);
        send(mpam_pkg::K_PAT, 30, 0);
        send(mpam_pkg::K_PAT, 24, 0);
        send(mpam_pkg::K_PAT, 23, 1);
        send(mpam_pkg::K_PAT, 2, 0);
        send(mpam_pkg::K_PAT, 3, 1);

        // random patterns: at least 1100 items, then on until six table-full answers or 2200 items
        while (n_items < 1100 || (sb.n_full < 6 && n_items < 2200)) begin
            r = $urandom_range(99);
            if (r < 4) send(mpam_pkg::K_PAT, $urandom_range(31, 26), $urandom_range(1));
            else if (r < 7) send(K_NONE, $urandom_range(31), $urandom_range(1));
            else if (r < 10) send_pattern(2, 0, 25);
            else send_pattern($urandom_range(12, 3), 0, 25);
        end

        drain();
        send(mpam_pkg::K_BUILD, $urandom_range(31), $urandom_range(1));
        send(mpam_pkg::K_BUILD, 0, 0);
        send(mpam_pkg::K_PAT, 4, 1);

        for (int i = 0; i < 720; i++) begin
            r = $urandom_range(99);
            if (r < 6) send(mpam_pkg::K_TEXT, $urandom_range(31, 26), $urandom_range(1));
            else if (r < 8) send(K_NONE, $urandom_range(31), $urandom_range(1));
            else if (r < 9) send(mpam_pkg::K_PAT, $urandom_range(31), $urandom_range(1));
            else if (r < 10) send(mpam_pkg::K_BUILD, $urandom_range(31), $urandom_range(1));
            else if (r < 55) send(mpam_pkg::K_TEXT, $urandom_range(3), $urandom_range(1));
            else send(mpam_pkg::K_TEXT, $urandom_range(25), $urandom_range(1));
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d transactions: %0d trie nodes, %0d table-full answers,",
                 n_items, sb.node_cnt, sb.n_full);
        $display("%0d results checked, %0d text matches", sb.n_checked, sb.n_match);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
